### src/smm_pkg.sv
`default_nettype none

package smm_pkg;

    // Default matrix side that the element stores are sized for.
    localparam int MAX_DIM_DEF = 64;

    // Limit set by the 6-bit row and column indices.
    localparam int IDX_LIMIT = 64;

    localparam int IDX_W  = 6;
    localparam int DIM_W  = 7;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 48;

    // Wide enough for row * MAX_DIM + col at the largest supported side.
    localparam int ADDR_CALC_W = 17;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_command;

    typedef struct packed {
        t_command                  command;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [ELEM_W-1:0]  element_value;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [SUM_W-1:0]   product_sum;
        logic                      last_of_row;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ISSUE = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

    // Control that travels down the multiply-accumulate pipeline with each read.
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last_k;
        logic             last_col;
        logic [IDX_W-1:0] col;
    } t_mac_tag;

endpackage

`default_nettype wire

### src/smm_ram.sv
`default_nettype none

module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output      logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/square_matrix_multiply_top.sv
// Square matrix multiply, C = A x B, with an exact fixed-point dot product.
//
// Command channel: an item is accepted at a rising edge where start is high
// and busy is low. A write-A or write-B item stores one element at its row
// and column and leaves busy low, so writes can stream at
// one item per cycle. Writes whose row or column is outside the stores are
// dropped. A compute item names a row of C; if the row is below the active
// side N, busy rises and the block returns N result items, one per column
// in column order, the last one marked by last_of_row.
// Each result is shown for exactly one cycle with o_strobe high; the
// receiver cannot stall it. Throughput is one multiply-accumulate per cycle
// through a single shared 16x16 multiplier and 48-bit accumulator; a row
// issues N*N products, column by column, each column's sum is registered
// at the output after its last product, and busy falls in the cycle that
// shows the last item of the row.
// The user must write the side register (i_cfg_we, i_cfg_wdata) only while idle; the block itself does not enforce it.
// Reset sets the side to 64 and empties the pipeline; the element stores
// are not cleared, and each element must be written before a compute reads it.

`default_nettype none

module square_matrix_multiply_top #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire smm_pkg::t_item                i_item,
    output      logic                          busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [smm_pkg::DIM_W-1:0]     i_cfg_wdata,
    output      logic                          o_strobe,
    output      smm_pkg::t_result              o_result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = smm_pkg::ADDR_CALC_W;
    localparam int IW    = smm_pkg::IDX_W;
    // The effective side is bounded by both the stores and the index width.
    localparam int LIM   = (MAX_DIM < smm_pkg::IDX_LIMIT) ? MAX_DIM : smm_pkg::IDX_LIMIT;
    localparam logic [smm_pkg::DIM_W-1:0] LIM_DIM = smm_pkg::DIM_W'(LIM);
    localparam logic [IW-1:0]             LIM_M1  = IW'(LIM - 1);

    // Side register.
    logic [smm_pkg::DIM_W-1:0] r_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= smm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_wdata;
        end
    end

    // N-1 after clamping the register to the legal range.
    logic [IW-1:0] w_nm1;

    always_comb begin
        priority if (r_dim == '0) begin
            w_nm1 = '0;
        end else if (r_dim > LIM_DIM) begin
            w_nm1 = LIM_M1;
        end else begin
            w_nm1 = IW'(r_dim - smm_pkg::DIM_W'(1));
        end
    end

    logic w_accept;
    logic w_wr_ok;
    logic w_we_a;
    logic w_we_b;
    logic [AW-1:0] w_waddr;

    assign w_accept = start && !busy;

    // Only indices that fall inside the stores are written.
    assign w_wr_ok = (CW'(i_item.row_index) < CW'(MAX_DIM)) &&
                     (CW'(i_item.col_index) < CW'(MAX_DIM));
    assign w_waddr = AW'(CW'(i_item.row_index) * CW'(MAX_DIM) + CW'(i_item.col_index));
    assign w_we_a  = w_accept && w_wr_ok && (i_item.command == smm_pkg::CMD_WRITE_A);
    assign w_we_b  = w_accept && w_wr_ok && (i_item.command == smm_pkg::CMD_WRITE_B);

    // Sequencer: walks k (inner) and j (outer) for the latched row.
    smm_pkg::t_state   r_state, n_state;
    logic [IW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_j, n_j;
    logic [IW-1:0]     r_row, n_row;
    logic [IW-1:0]     r_last, n_last;
    smm_pkg::t_mac_tag w_tag0;
    smm_pkg::t_mac_tag r_tag1;
    smm_pkg::t_mac_tag r_tag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k    <= n_k;
        r_j    <= n_j;
        r_row  <= n_row;
        r_last <= n_last;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_row   = r_row;
        n_last  = r_last;
        w_tag0  = '0;
        unique case (r_state)
            smm_pkg::ST_IDLE: begin
                // A row at or beyond N yields nothing, so the block stays idle.
                if (w_accept && (i_item.command == smm_pkg::CMD_COMPUTE) &&
                    (i_item.row_index <= w_nm1)) begin
                    n_state = smm_pkg::ST_ISSUE;
                    n_k     = '0;
                    n_j     = '0;
                    n_row   = i_item.row_index;
                    n_last  = w_nm1;
                end
            end
            smm_pkg::ST_ISSUE: begin
                w_tag0.vld      = 1'b1;
                w_tag0.first    = (r_k == '0);
                w_tag0.last_k   = (r_k == r_last);
                w_tag0.last_col = (r_j == r_last);
                w_tag0.col      = r_j;
                if (r_k == r_last) begin
                    n_k = '0;
                    if (r_j == r_last) begin
                        n_state = smm_pkg::ST_DRAIN;
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            smm_pkg::ST_DRAIN: begin
                // Leave once the last column's sum reaches the output register.
                if (r_tag2.vld && r_tag2.last_k && r_tag2.last_col) begin
                    n_state = smm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smm_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != smm_pkg::ST_IDLE);

    // Read addresses: A walks along the row, B walks down column j.
    logic [AW-1:0]                 w_raddr_a;
    logic [AW-1:0]                 w_raddr_b;
    logic [smm_pkg::ELEM_W-1:0]    w_rd_a;
    logic [smm_pkg::ELEM_W-1:0]    w_rd_b;

    assign w_raddr_a = AW'(CW'(r_row) * CW'(MAX_DIM) + CW'(r_k));
    assign w_raddr_b = AW'(CW'(r_k) * CW'(MAX_DIM) + CW'(r_j));

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_item.element_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_item.element_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    // Pipeline: read data (tag1), product register (tag2), accumulate and output.
    logic signed [smm_pkg::PROD_W-1:0] r_prod;
    logic signed [smm_pkg::SUM_W-1:0]  r_acc;
    logic signed [smm_pkg::SUM_W-1:0]  w_acc_base;
    logic signed [smm_pkg::SUM_W-1:0]  w_acc_next;
    logic                              r_strobe;
    smm_pkg::t_result                  r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1   <= '0;
            r_tag2   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_tag1   <= w_tag0;
            r_tag2   <= r_tag1;
            r_strobe <= r_tag2.vld && r_tag2.last_k;
        end
    end

    // The first product of each column restarts the sum.
    assign w_acc_base = r_tag2.first ? '0 : r_acc;
    assign w_acc_next = w_acc_base + smm_pkg::SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_rd_a) * $signed(w_rd_b);
        if (r_tag2.vld) begin
            r_acc <= w_acc_next;
        end
        if (r_tag2.vld && r_tag2.last_k) begin
            r_result.out_row     <= r_row;
            r_result.out_col     <= r_tag2.col;
            r_result.product_sum <= w_acc_next;
            r_result.last_of_row <= r_tag2.last_col;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

### src/smm_checker.sv
`default_nettype none

module smm_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             busy,
    input wire logic             o_strobe,
    input wire smm_pkg::t_result o_result
);

    // A row ends with busy falling in the same cycle as its marked last item.
    a_end_of_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe && o_result.last_of_row)
        else $error("busy fell without the last item of the row");

    // Every item belongs to a compute that was running in the prior cycle.
    a_item_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("item shown without a compute in progress");

    // More columns remain, so the block must still be busy.
    a_busy_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_of_row |-> busy)
        else $error("block idle before the row was finished");

    // Columns of a row are never back to back; N is at least two when a row has several.
    a_column_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_of_row |=> !o_strobe)
        else $error("two columns of one row shown back to back");

endmodule

bind square_matrix_multiply_top smm_checker u_smm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

### sim/square_matrix_multiply_top_test.sv
`default_nettype none

module square_matrix_multiply_top_test;

    import smm_pkg::*;

    localparam int SIDE_MAX = MAX_DIM_DEF;
    localparam int STORE_SIZE = SIDE_MAX * SIDE_MAX;

    // Side of the top-left corner of both stores that is written at the start.
    // Every compute in the run stays inside it.
    localparam int LOAD_SIDE = 5;

    // The command encoding that the block leaves unused.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

    localparam int RANDOM_ITEMS = 60;
    // This is well past the time that a full row at side 64 takes.
    localparam int DRAIN_LIMIT = 6000;
    localparam int RUN_LIMIT_CYCLES = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_item i_item = '0;
    logic i_cfg_we = 1'b0;
    logic [DIM_W-1:0] i_cfg_wdata = '0;
    logic busy;
    logic o_strobe;
    t_result o_result;

    square_matrix_multiply_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Our own copy of both element stores and of the side register.
    logic signed [ELEM_W-1:0] a_elems [0:STORE_SIZE-1];
    logic signed [ELEM_W-1:0] b_elems [0:STORE_SIZE-1];
    logic [DIM_W-1:0] side_reg = DIM_RESET;

    // Elements of C that the block still owes us, oldest first.
    t_result c_elems_due[$];

    int err_count = 0;
    int items_sent = 0;
    int rows_computed = 0;
    int elems_checked = 0;

    // When this is low the sender never pauses between items.
    logic sender_idles = 1'b1;

    // The side actually used: a zero setting acts as 1, anything above the
    // store size (and the 6-bit index range) acts as 64.
    function automatic int active_side();
        if (side_reg == 0)
            return 1;
        if (side_reg > SIDE_MAX)
            return SIDE_MAX;
        return int'(side_reg);
    endfunction

    function automatic t_item make_item(input logic [1:0] cmd, input int row, input int col,
                                        input logic [ELEM_W-1:0] val);
        t_item it;
        it.command = t_command'(cmd);
        it.row_index = IDX_W'(row);
        it.col_index = IDX_W'(col);
        it.element_value = val;
        return it;
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        return ELEM_W'($urandom);
    endfunction

    // Mostly a row or column inside the active side, now and then anywhere
    // in the stores.
    function automatic int pick_index(input int n);
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, SIDE_MAX - 1);
        return $urandom_range(0, n - 1);
    endfunction

    // Queues every element of one row of C, each the exact dot product of
    // row `row` of A with one column of B.
    task automatic queue_row_of_c(input int row);
        int n;
        longint acc;
        t_result elem;
        n = active_side();
        if (row >= n)
            return;
        rows_computed++;
        for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
                acc += longint'(a_elems[row * SIDE_MAX + k]) * longint'(b_elems[k * SIDE_MAX + j]);
            elem.out_row = IDX_W'(row);
            elem.out_col = IDX_W'(j);
            elem.product_sum = acc[SUM_W-1:0];
            elem.last_of_row = (j == n - 1);
            c_elems_due.push_back(elem);
        end
    endtask

    // Applies one accepted item to our copy of the stores.
    task automatic track_command(input t_item it);
        int addr;
        addr = int'(it.row_index) * SIDE_MAX + int'(it.col_index);
        case (it.command)
            CMD_WRITE_A: begin
                a_elems[addr] = it.element_value;
            end
            CMD_WRITE_B: begin
                b_elems[addr] = it.element_value;
            end
            CMD_COMPUTE: begin
                queue_row_of_c(int'(it.row_index));
            end
            default: begin
            end
        endcase
    endtask

    // Presents one item, holds it until the block takes it, then predicts.
    // Start stays high on return so back-to-back items need no extra edge.
    task automatic send_item(input t_item it);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        track_command(it);
        items_sent++;
    endtask

    // Drops start and waits until every owed element has come and the block
    // is idle, then lets a few more cycles pass.
    task automatic drain_results(input int settle);
        int waited;
        waited = 0;
        start <= 1'b0;
        while ((c_elems_due.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (c_elems_due.size() != 0) begin
            $display("%0t: %0d expected elements of C never arrived, next expected row %0d col %0d",
                     $time, c_elems_due.size(), c_elems_due[0].out_row, c_elems_due[0].out_col);
            err_count++;
            c_elems_due.delete();
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // The side register is only written once the block has gone quiet.
    task automatic set_side(input logic [DIM_W-1:0] side);
        drain_results(4);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= side;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        side_reg = side;
    endtask

    // Every result is taken at the edge that ends its strobe cycle and is
    // matched against the oldest owed element of C.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (c_elems_due.size() == 0) begin
                $display("%0t: unexpected element, actual row %0d col %0d sum %0d last %0b",
                         $time, o_result.out_row, o_result.out_col,
                         o_result.product_sum, o_result.last_of_row);
                err_count++;
            end else begin
                if (o_result.out_row !== c_elems_due[0].out_row
                        || o_result.out_col !== c_elems_due[0].out_col
                        || o_result.product_sum !== c_elems_due[0].product_sum
                        || o_result.last_of_row !== c_elems_due[0].last_of_row) begin
                    $display("%0t: mismatch, expected row %0d col %0d sum %0d last %0b",
                             $time, c_elems_due[0].out_row, c_elems_due[0].out_col,
                             c_elems_due[0].product_sum, c_elems_due[0].last_of_row);
                    $display("%0t:           actual   row %0d col %0d sum %0d last %0b",
                             $time, o_result.out_row, o_result.out_col,
                             o_result.product_sum, o_result.last_of_row);
                    err_count++;
                end
                void'(c_elems_due.pop_front());
                elems_checked++;
            end
        end
    end

    // The stores come out of reset undefined, so the corner that every
    // compute reads is written before any compute. The last loaded row of A
    // and the first and last loaded columns of B carry the extreme values so
    // that the widest rows reach the largest sums.
    task automatic load_both_matrices();
        for (int r = 0; r < LOAD_SIDE; r++)
            for (int c = 0; c < LOAD_SIDE; c++)
                send_item(make_item(CMD_WRITE_A, r, c,
                                    (r == LOAD_SIDE - 1) ? ELEM_MIN : rand_elem()));
        for (int r = 0; r < LOAD_SIDE; r++)
            for (int c = 0; c < LOAD_SIDE; c++)
                send_item(make_item(CMD_WRITE_B, r, c,
                                    (c == 0) ? ELEM_MIN :
                                    (c == LOAD_SIDE - 1) ? ELEM_MAX : rand_elem()));
    endtask

    // A side of one, set directly and through a zero setting. Rows past the
    // side and the spare command must produce nothing.
    task automatic test_unit_side();
        set_side(7'd1);
        send_item(make_item(CMD_COMPUTE, 0, 63, ELEM_MAX));
        send_item(make_item(CMD_COMPUTE, 1, 0, ELEM_MIN));
        send_item(make_item(CMD_SPARE, 63, 63, 16'hFFFF));
        set_side(7'd0);
        send_item(make_item(CMD_COMPUTE, 0, 0, 16'h0000));
        send_item(make_item(CMD_COMPUTE, 63, 63, 16'hFFFF));
    endtask

    // Side two with the extreme element values, plus two writes far outside
    // the side that land in the stores without touching the entries in use.
    task automatic test_two_by_two_extremes();
        set_side(7'd2);
        send_item(make_item(CMD_WRITE_A, 0, 0, ELEM_MIN));
        send_item(make_item(CMD_WRITE_A, 0, 1, ELEM_MIN));
        send_item(make_item(CMD_WRITE_B, 0, 0, ELEM_MIN));
        send_item(make_item(CMD_WRITE_B, 1, 0, ELEM_MIN));
        send_item(make_item(CMD_WRITE_B, 0, 1, ELEM_MAX));
        send_item(make_item(CMD_WRITE_B, 1, 1, ELEM_MAX));
        send_item(make_item(CMD_WRITE_A, 1, 0, ELEM_MAX));
        send_item(make_item(CMD_WRITE_A, 1, 1, 16'sh0001));
        send_item(make_item(CMD_WRITE_A, 40, 63, ELEM_MAX));
        send_item(make_item(CMD_WRITE_B, 63, 5, ELEM_MIN));
        send_item(make_item(CMD_COMPUTE, 0, 0, 16'h0000));
        send_item(make_item(CMD_COMPUTE, 1, 63, 16'hFFFF));
    endtask

    // Phases at small random sides: element writes, whole rows of A written
    // and then computed, single computes (some past the side) and the spare
    // command. The last stretch runs with no pauses from the sender.
    task automatic test_random_traffic();
        int n;
        int pick;
        int row;
        int done;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                set_side(7'd1);
            else
                set_side(DIM_W'($urandom_range(2, LOAD_SIDE)));
            n = active_side();
            repeat (16) begin
                if (done >= RANDOM_ITEMS - 30)
                    sender_idles = 1'b0;
                pick = $urandom_range(0, 9);
                if (pick <= 2) begin
                    send_item(make_item(CMD_WRITE_A, pick_index(n), pick_index(n), rand_elem()));
                end else if (pick <= 4) begin
                    send_item(make_item(CMD_WRITE_B, pick_index(n), pick_index(n), rand_elem()));
                end else if (pick == 5) begin
                    row = $urandom_range(0, n - 1);
                    for (int k = 0; k < n; k++)
                        send_item(make_item(CMD_WRITE_A, row, k, rand_elem()));
                    send_item(make_item(CMD_COMPUTE, row, $urandom_range(0, 63), rand_elem()));
                    done += n;
                end else if (pick <= 8) begin
                    send_item(make_item(CMD_COMPUTE, pick_index(n), $urandom_range(0, 63),
                                        rand_elem()));
                end else begin
                    send_item(make_item(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                                        rand_elem()));
                end
                done++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_both_matrices();
        test_unit_side();
        test_two_by_two_extremes();
        test_random_traffic();
        drain_results(20);

        $display("Sent %0d items with %0d row computes; checked %0d elements of C.",
                 items_sent, rows_computed, elems_checked);
        $display("Sides: 0, 1, 2 and random sides up to %0d, with extreme element values.",
                 LOAD_SIDE);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_CYCLES * 8);
        $display("Run stopped after %0d cycles without finishing.", RUN_LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/smm_pkg.sv
src/smm_ram.sv
src/square_matrix_multiply_top.sv
src/smm_checker.sv
sim/square_matrix_multiply_top_test.sv
